/* hw/rtl/vcmn_pkg.sv */
// ----------------------------------------------------------------------------
// vcmn_pkg
// shared constants, register codes and types of the crop, mirror and
// normalize pixel block
// ----------------------------------------------------------------------------
`default_nettype none

package vcmn_pkg;

    localparam int MAX_CHANNELS = 4;
    localparam int MAX_EDGE     = 1024;

    localparam int DIM_W      = 11;
    localparam int POS_W      = 10;
    localparam int PIX_W      = 8;
    localparam int MEAN_W     = 16;
    localparam int CH_W       = 2;
    localparam int MODE_W     = 3;
    localparam int GAIN_W     = 24;
    localparam int MEANS_W    = MEAN_W * MAX_CHANNELS;
    localparam int VAL_W      = 32;
    localparam int IDX_W      = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = CH_W;
    localparam int M_TDATA_W = 56;

    localparam int DIFF_W     = MEAN_W + 1;
    localparam int PROD_W     = DIFF_W + GAIN_W + 1;
    localparam int WIDE_W     = PROD_W + 1;
    localparam int IDX_PROD_W = POS_W + DIM_W;
    localparam int FRAC_DROP  = 8;

    localparam logic signed [WIDE_W-1:0] RND_HALF = WIDE_W'(128);
    localparam logic signed [WIDE_W-1:0] Q16_ONE  = WIDE_W'(65536);
    localparam logic signed [WIDE_W-1:0] VAL_MAX  = WIDE_W'(64'sh7FFF_FFFF);
    localparam logic signed [WIDE_W-1:0] VAL_MIN  = -WIDE_W'(64'sh8000_0000);

    localparam int MODE_MIRROR_BIT = 0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEIGHT   = 3'd0,
        CFG_WIDTH    = 3'd1,
        CFG_CROP     = 3'd2,
        CFG_ROW_OFF  = 3'd3,
        CFG_COL_OFF  = 3'd4,
        CFG_MODE     = 3'd5,
        CFG_GAIN     = 3'd6,
        CFG_MEANS    = 3'd7
    } t_cfg_index;

    typedef enum logic [1:0] {
        NORM_PIXEL_MEAN   = 2'd0,
        NORM_CHANNEL_MEAN = 2'd1,
        NORM_RESCALE      = 2'd2
    } t_norm_sel;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [GAIN_W-1:0]  gain;
        logic [MEANS_W-1:0] means;
    } t_cfg;

    typedef struct packed {
        logic [DIM_W-1:0] h;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] out_w;
        logic [POS_W-1:0] out_h_m1;
        logic [POS_W-1:0] out_w_m1;
        logic [POS_W-1:0] roff;
        logic [POS_W-1:0] coff;
    } t_geom;

    typedef struct packed {
        logic [PIX_W-1:0]  x;
        logic [MEAN_W-1:0] mean;
        logic [POS_W-1:0]  orow;
        logic [POS_W-1:0]  ocol;
        logic              last;
    } t_stage_a;

endpackage

`default_nettype wire

/* hw/rtl/vcmn_cfg.sv */
// ----------------------------------------------------------------------------
// vcmn_cfg
// configuration registers and the registered crop window geometry
// ----------------------------------------------------------------------------
`default_nettype none

module vcmn_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [vcmn_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [vcmn_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output vcmn_pkg::t_cfg                        o_cfg,
    output vcmn_pkg::t_geom                       o_geom,
    output logic                                  o_busy
);
    import vcmn_pkg::*;

    logic [DIM_W-1:0]   r_height;
    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_crop;
    logic [POS_W-1:0]   r_row_off;
    logic [POS_W-1:0]   r_col_off;
    logic [MODE_W-1:0]  r_mode;
    logic [GAIN_W-1:0]  r_gain;
    logic [MEANS_W-1:0] r_means;
    logic               r_settle;
    t_geom              r_geom;
    t_geom              n_geom;

    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] e;
    logic [DIM_W-1:0] out_h;
    logic [DIM_W-1:0] out_w;
    logic [DIM_W-1:0] rspan;
    logic [DIM_W-1:0] cspan;
    logic [DIM_W-1:0] roff;
    logic [DIM_W-1:0] coff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height  <= DIM_W'(1);
            r_width   <= DIM_W'(1);
            r_crop    <= '0;
            r_row_off <= '0;
            r_col_off <= '0;
            r_mode    <= MODE_W'(4);
            r_gain    <= GAIN_W'(65536);
            r_means   <= '0;
            r_settle  <= 1'b1;
        end else begin
            r_settle <= i_cfg_we;
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_HEIGHT:  r_height  <= i_cfg_data[DIM_W-1:0];
                    CFG_WIDTH:   r_width   <= i_cfg_data[DIM_W-1:0];
                    CFG_CROP:    r_crop    <= i_cfg_data[DIM_W-1:0];
                    CFG_ROW_OFF: r_row_off <= i_cfg_data[POS_W-1:0];
                    CFG_COL_OFF: r_col_off <= i_cfg_data[POS_W-1:0];
                    CFG_MODE:    r_mode    <= i_cfg_data[MODE_W-1:0];
                    CFG_GAIN:    r_gain    <= i_cfg_data[GAIN_W-1:0];
                    CFG_MEANS:   r_means   <= i_cfg_data[MEANS_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // clamp plane size, fit the square window inside the plane or, with crop zero, use the whole plane
    always_comb begin
        h = r_height;
        if (r_height == '0) begin
            h = DIM_W'(1);
        end else if (r_height > DIM_W'(MAX_EDGE)) begin
            h = DIM_W'(MAX_EDGE);
        end
        w = r_width;
        if (r_width == '0) begin
            w = DIM_W'(1);
        end else if (r_width > DIM_W'(MAX_EDGE)) begin
            w = DIM_W'(MAX_EDGE);
        end
        e = r_crop;
        if (e > h) begin
            e = h;
        end
        if (e > w) begin
            e = w;
        end
        rspan = h - e;
        cspan = w - e;
        if (r_crop == '0) begin
            out_h = h;
            out_w = w;
            roff  = '0;
            coff  = '0;
        end else begin
            out_h = e;
            out_w = e;
            roff  = ({1'b0, r_row_off} > rspan) ? rspan : {1'b0, r_row_off};
            coff  = ({1'b0, r_col_off} > cspan) ? cspan : {1'b0, r_col_off};
        end
        n_geom.h        = h;
        n_geom.w        = w;
        n_geom.out_w    = out_w;
        n_geom.out_h_m1 = POS_W'(out_h - DIM_W'(1));
        n_geom.out_w_m1 = POS_W'(out_w - DIM_W'(1));
        n_geom.roff     = POS_W'(roff);
        n_geom.coff     = POS_W'(coff);
    end

    always_ff @(posedge i_clk) begin
        r_geom <= n_geom;
    end

    assign o_geom      = r_geom;
    assign o_cfg.mode  = r_mode;
    assign o_cfg.gain  = r_gain;
    assign o_cfg.means = r_means;
    assign o_busy      = r_settle;

endmodule

`default_nettype wire

/* hw/rtl/vcmn_scan.sv */
// ----------------------------------------------------------------------------
// vcmn_scan
// raster position counters, crop window test, mirror and mean select
// ----------------------------------------------------------------------------
`default_nettype none

module vcmn_scan (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  vcmn_pkg::t_cfg                     i_cfg,
    input  vcmn_pkg::t_geom                    i_geom,
    input  wire logic                          i_busy,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [vcmn_pkg::PIX_W-1:0]    i_pixel,
    input  wire logic [vcmn_pkg::MEAN_W-1:0]   i_pixel_mean,
    input  wire logic [vcmn_pkg::CH_W-1:0]     i_channel,
    input  wire logic                          i_adv,
    output logic                               o_a_valid,
    output vcmn_pkg::t_stage_a                 o_a
);
    import vcmn_pkg::*;

    logic [POS_W-1:0] r_row;
    logic [POS_W-1:0] r_col;
    logic [POS_W-1:0] n_row;
    logic [POS_W-1:0] n_col;
    logic             r_a_valid;
    t_stage_a         r_a;
    t_stage_a         n_a;

    logic             accept;
    logic             hit;
    logic [POS_W-1:0] orow;
    logic [POS_W-1:0] ocol;
    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;
    logic [CH_W-1:0]  ch;

    assign o_ready = !i_busy && (!r_a_valid || i_adv);
    assign accept  = i_valid && o_ready;

    always_comb begin
        col_inc = {1'b0, r_col} + DIM_W'(1);
        row_inc = {1'b0, r_row} + DIM_W'(1);
        n_col   = POS_W'(col_inc);
        n_row   = r_row;
        if (col_inc >= i_geom.w) begin
            n_col = '0;
            n_row = (row_inc >= i_geom.h) ? '0 : POS_W'(row_inc);
        end
    end

    always_comb begin
        orow = r_row - i_geom.roff;
        ocol = r_col - i_geom.coff;
        hit  = (r_row >= i_geom.roff) && (orow <= i_geom.out_h_m1)
            && (r_col >= i_geom.coff) && (ocol <= i_geom.out_w_m1);
        ch = i_channel;
        if (i_channel > CH_W'(MAX_CHANNELS - 1)) begin
            ch = CH_W'(MAX_CHANNELS - 1);
        end
        n_a.x    = i_pixel;
        n_a.orow = orow;
        n_a.last = (orow == i_geom.out_h_m1) && (ocol == i_geom.out_w_m1);
        n_a.ocol = i_cfg.mode[MODE_MIRROR_BIT] ? (i_geom.out_w_m1 - ocol) : ocol;
        n_a.mean = (t_norm_sel'(i_cfg.mode[2:1]) == NORM_PIXEL_MEAN)
            ? i_pixel_mean : i_cfg.means[MEAN_W*ch +: MEAN_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= '0;
            r_a_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (!r_a_valid || i_adv) begin
                r_a_valid <= accept && hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a <= n_a;
        end
    end

    assign o_a_valid = r_a_valid;
    assign o_a       = r_a;

    a_row_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> (r_a.orow <= i_geom.out_h_m1))
        else $error("stage a row outside window");

    a_last_on_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a.last) |-> (r_a.orow == i_geom.out_h_m1))
        else $error("last pixel flagged off the bottom row");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !i_adv) |=> (r_a_valid && !$past(accept)))
        else $error("stage a item lost or overwritten during stall");

endmodule

`default_nettype wire

/* hw/rtl/vcmn_norm.sv */
// ----------------------------------------------------------------------------
// vcmn_norm
// mean subtract or rescale multiply, rounding, saturation and output index
// ----------------------------------------------------------------------------
`default_nettype none

module vcmn_norm (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  vcmn_pkg::t_cfg                     i_cfg,
    input  vcmn_pkg::t_geom                    i_geom,
    input  wire logic                          i_a_valid,
    input  vcmn_pkg::t_stage_a                 i_a,
    output logic                               o_adv,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [vcmn_pkg::VAL_W-1:0]  o_value,
    output logic [vcmn_pkg::IDX_W-1:0]         o_out_index,
    output logic                               o_plane_last
);
    import vcmn_pkg::*;

    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        logic                     rescale;
        logic [IDX_PROD_W-1:0]    idx_prod;
        logic [POS_W-1:0]         ocol;
        logic                     last;
    } t_stage_b;

    logic                     r_b_valid;
    t_stage_b                 r_b;
    t_stage_b                 n_b;
    logic                     r_c_valid;
    logic signed [VAL_W-1:0]  r_c_value;
    logic [IDX_W-1:0]         r_c_index;
    logic                     r_c_last;
    logic signed [VAL_W-1:0]  n_c_value;
    logic [IDX_W-1:0]         n_c_index;

    logic                     en_b;
    logic                     en_c;
    logic signed [DIFF_W-1:0] opnd;
    logic signed [GAIN_W:0]   gain_s;
    logic signed [WIDE_W-1:0] wide;

    assign en_c  = !r_c_valid || i_ready;
    assign en_b  = !r_b_valid || en_c;
    assign o_adv = en_b;

    always_comb begin
        case (t_norm_sel'(i_cfg.mode[2:1]))
            NORM_PIXEL_MEAN, NORM_CHANNEL_MEAN: begin
                n_b.rescale = 1'b0;
                opnd = $signed({1'b0, i_a.x, 8'd0}) - $signed({1'b0, i_a.mean});
            end
            default: begin
                n_b.rescale = 1'b1;
                opnd = $signed({{(DIFF_W-PIX_W-1){1'b0}}, i_a.x, 1'b0});
            end
        endcase
        gain_s       = $signed({1'b0, i_cfg.gain});
        n_b.prod     = opnd * gain_s;
        n_b.idx_prod = i_a.orow * i_geom.out_w;
        n_b.ocol     = i_a.ocol;
        n_b.last     = i_a.last;
    end

    always_comb begin
        if (r_b.rescale) begin
            wide = WIDE_W'(r_b.prod) - Q16_ONE;
        end else begin
            wide = (WIDE_W'(r_b.prod) + RND_HALF) >>> FRAC_DROP;
        end
        if (wide > VAL_MAX) begin
            n_c_value = VAL_W'(VAL_MAX);
        end else if (wide < VAL_MIN) begin
            n_c_value = VAL_W'(VAL_MIN);
        end else begin
            n_c_value = VAL_W'(wide);
        end
        n_c_index = IDX_W'(r_b.idx_prod + IDX_PROD_W'(r_b.ocol));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (en_b) begin
                r_b_valid <= i_a_valid;
            end
            if (en_c) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b && i_a_valid) begin
            r_b <= n_b;
        end
        if (en_c && r_b_valid) begin
            r_c_value <= n_c_value;
            r_c_index <= n_c_index;
            r_c_last  <= r_b.last;
        end
    end

    assign o_valid      = r_c_valid;
    assign o_value      = r_c_value;
    assign o_out_index  = r_c_index;
    assign o_plane_last = r_c_last;

    b_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !en_c) |=> r_b_valid)
        else $error("stage b item dropped during stall");

    b_take_from_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en_b && i_a_valid) |=> r_b_valid)
        else $error("stage a item not taken into stage b");

endmodule

`default_nettype wire

/* hw/rtl/video_crop_mirror_normalize.sv */
// ----------------------------------------------------------------------------
// video_crop_mirror_normalize
// crops, optionally mirrors and normalizes a planar 8-bit pixel stream
// ----------------------------------------------------------------------------
// usage
//   input beats carry one raster-order pixel of the current plane with its
//   per-pixel mean (tdata) and channel index (tuser); the block counts rows
//   and columns itself, so one plane is source height * width beats
//   output beats carry the Q16.16 value and the index within the cropped
//   plane (tdata); tlast marks the last pixel of the cropped plane
//   pixels outside the crop window are accepted and produce no beat
//   one beat per cycle is accepted while tready is high; a kept pixel passes
//   the position stage, multiply stage and result register to the output
//   configuration is written through the plain write port while no beats
//   are in flight; the input is held off in the cycle after each write
//   while the window geometry register reloads
//   after reset the counters sit at the first pixel, all configuration
//   registers hold their defaults and the input opens the cycle after reset ends
//   when the receiver stalls the pipeline fills its three stages and then
//   drops tready on the input; no beat is lost
// ----------------------------------------------------------------------------
`default_nettype none

module video_crop_mirror_normalize (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [vcmn_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [vcmn_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // pixel [7:0], pixel_mean [23:8]
    input  wire logic [vcmn_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // channel [1:0]
    input  wire logic [vcmn_pkg::S_TUSER_W-1:0]     i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // value [31:0], out_index [51:32], zero [55:52]
    output logic [vcmn_pkg::M_TDATA_W-1:0]          o_m_axis_tdata,
    output logic                                    o_m_axis_tlast
);
    import vcmn_pkg::*;

    t_cfg                    cfg;
    t_geom                   geom;
    logic                    busy;
    logic                    a_valid;
    t_stage_a                a_item;
    logic                    adv;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        out_index;

    vcmn_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_geom      (geom),
        .o_busy      (busy)
    );

    vcmn_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_geom       (geom),
        .i_busy       (busy),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_pixel      (i_s_axis_tdata[PIX_W-1:0]),
        .i_pixel_mean (i_s_axis_tdata[PIX_W +: MEAN_W]),
        .i_channel    (i_s_axis_tuser[CH_W-1:0]),
        .i_adv        (adv),
        .o_a_valid    (a_valid),
        .o_a          (a_item)
    );

    vcmn_norm u_norm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_geom       (geom),
        .i_a_valid    (a_valid),
        .i_a          (a_item),
        .o_adv        (adv),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_value      (value),
        .o_out_index  (out_index),
        .o_plane_last (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{(M_TDATA_W-VAL_W-IDX_W){1'b0}}, out_index, value};

endmodule

`default_nettype wire
